// File: sv/tbf_pkg.sv
package tbf_pkg;

    localparam int VRAM_BYTES = 8192;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);

    typedef enum logic [2:0] {
        K_VRAM_WRITE = 3'd0,
        K_LINE_START = 3'd1,
        K_FETCH_TILE = 3'd2,
        K_DATA_LOW   = 3'd3,
        K_DATA_HIGH  = 3'd4,
        K_PUSH       = 3'd5
    } t_kind;

    localparam logic [1:0] CFG_LCD_CONTROL = 2'd0;
    localparam logic [1:0] CFG_SCROLL_X    = 2'd1;
    localparam logic [1:0] CFG_SCROLL_Y    = 2'd2;

    typedef struct packed {
        t_kind                op;
        logic [VRAM_AW-1:0]   vram_address;
        logic [7:0]           vram_data;
        logic [7:0]           start_column;
        logic                 window_select;
        logic [7:0]           line_number;
        logic                 fill_over;
    } t_cmd;

    typedef struct packed {
        logic [7:0] lcd_control;
        logic [7:0] scroll_x;
        logic [7:0] scroll_y;
    } t_cfg;

endpackage

// File: sv/tile_background_fetcher_top.sv
// channel  direction  handshake                   payload
// in       input      i_in_valid / o_in_ready     i_kind .. i_downstream_fill
// out      output     o_out_valid / i_out_ready   o_pixel_color, o_refused, o_last_pixel
// cfg      input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Video memory write and line start complete in the back end's idle state; unused kinds drop in front.
// Fetch steps pass through the read state, since the video memory read is registered.
// Push: 8 - discard words out, or 1 when refused, each waiting for a free output.
// Reset is synchronous; video memory contents are not cleared.
// A stalled output holds the back end while the front end keeps filling its queue.
module tile_background_fetcher_top #(
    parameter int FIFO_PUSH_LIMIT = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_kind,
    input  logic [tbf_pkg::VRAM_AW-1:0]  i_vram_address,
    input  logic [7:0]                   i_vram_data,
    input  logic [7:0]                   i_start_column,
    input  logic                         i_window_select,
    input  logic [7:0]                   i_line_number,
    input  logic [4:0]                   i_downstream_fill,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_pixel_color,
    output logic                         o_refused,
    output logic                         o_last_pixel,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [7:0]                   i_cfg_data
);
    import tbf_pkg::*;

    t_cfg r_cfg;
    logic fq_valid;
    logic fq_ready;
    t_cmd fq_cmd;
    logic qb_valid;
    logic qb_ready;
    t_cmd qb_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LCD_CONTROL: r_cfg.lcd_control <= i_cfg_data;
                CFG_SCROLL_X:    r_cfg.scroll_x    <= i_cfg_data;
                CFG_SCROLL_Y:    r_cfg.scroll_y    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tbf_front #(
        .FIFO_PUSH_LIMIT(FIFO_PUSH_LIMIT)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_vram_address    (i_vram_address),
        .i_vram_data       (i_vram_data),
        .i_start_column    (i_start_column),
        .i_window_select   (i_window_select),
        .i_line_number     (i_line_number),
        .i_downstream_fill (i_downstream_fill),
        .o_q_valid         (fq_valid),
        .i_q_ready         (fq_ready),
        .o_q_cmd           (fq_cmd)
    );

    tbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_cmd   (fq_cmd),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_cmd   (qb_cmd)
    );

    tbf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (qb_valid),
        .o_q_ready     (qb_ready),
        .i_q_cmd       (qb_cmd),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_color (o_pixel_color),
        .o_refused     (o_refused),
        .o_last_pixel  (o_last_pixel)
    );

    a_refused_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_refused |-> o_last_pixel && o_pixel_color == 2'b00)
        else $error("refused word not marked last");

    a_reset_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_reset_in_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

endmodule

// File: sv/tbf_front.sv
module tbf_front #(
    parameter int FIFO_PUSH_LIMIT = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_kind,
    input  logic [tbf_pkg::VRAM_AW-1:0]  i_vram_address,
    input  logic [7:0]                   i_vram_data,
    input  logic [7:0]                   i_start_column,
    input  logic                         i_window_select,
    input  logic [7:0]                   i_line_number,
    input  logic [4:0]                   i_downstream_fill,
    output logic                         o_q_valid,
    input  logic                         i_q_ready,
    output tbf_pkg::t_cmd                o_q_cmd
);
    import tbf_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    logic known;
    t_cmd n_cmd;

    always_comb begin
        case (i_kind)
            K_VRAM_WRITE, K_LINE_START, K_FETCH_TILE,
            K_DATA_LOW, K_DATA_HIGH, K_PUSH: known = 1'b1;
            default: known = 1'b0;
        endcase
        n_cmd.op            = t_kind'(i_kind);
        n_cmd.vram_address  = i_vram_address;
        n_cmd.vram_data     = i_vram_data;
        n_cmd.start_column  = i_start_column;
        n_cmd.window_select = i_window_select;
        n_cmd.line_number   = i_line_number;
        n_cmd.fill_over     = i_downstream_fill > 5'(FIFO_PUSH_LIMIT);
    end

    assign o_in_ready = !r_valid || i_q_ready;
    assign o_q_valid  = r_valid;
    assign o_q_cmd    = r_cmd;

    // drop unused kinds here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid && known;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: sv/tbf_queue.sv
module tbf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tbf_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output tbf_pkg::t_cmd o_cmd
);
    import tbf_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          push;
    logic          pop;

    assign o_ready = r_count != (PW+1)'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_slot[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: sv/tbf_back.sv
module tbf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tbf_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    output logic          o_q_ready,
    input  tbf_pkg::t_cmd i_q_cmd,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [1:0]    o_pixel_color,
    output logic          o_refused,
    output logic          o_last_pixel
);
    import tbf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    logic [7:0]         r_vram [VRAM_BYTES];
    logic [7:0]         r_rd_data;
    t_state             r_state;
    t_kind              r_rd_kind;
    logic               r_refuse;
    logic [2:0]         r_bit;
    logic [7:0]         r_pixel_column;
    logic               r_window_mode;
    logic [7:0]         r_scan_line;
    logic [7:0]         r_tile_row_y;
    logic [7:0]         r_tile_index;
    logic [VRAM_AW-1:0] r_tile_data_address;
    logic [7:0]         r_plane_low;
    logic [7:0]         r_plane_high;
    logic [2:0]         r_discard_count;
    logic               r_out_valid;
    logic [1:0]         r_pixel_color;
    logic               r_refused;
    logic               r_last_pixel;

    logic               pop;
    logic               out_free;
    logic [7:0]         pos_x;
    logic [7:0]         pos_y;
    logic               map_sel;
    logic [VRAM_AW-1:0] map_addr;
    logic [VRAM_AW-1:0] data_base;
    logic [VRAM_AW-1:0] low_addr;
    logic [VRAM_AW-1:0] rd_addr;

    assign o_q_ready     = r_state == S_IDLE;
    assign pop           = o_q_ready && i_q_valid;
    assign out_free      = !r_out_valid || i_out_ready;
    assign o_out_valid   = r_out_valid;
    assign o_pixel_color = r_pixel_color;
    assign o_refused     = r_refused;
    assign o_last_pixel  = r_last_pixel;

    always_comb begin
        pos_x    = r_pixel_column + i_cfg.scroll_x;
        pos_y    = r_scan_line + i_cfg.scroll_y;
        map_sel  = r_window_mode ? i_cfg.lcd_control[6] : i_cfg.lcd_control[3];
        map_addr = {2'b11, map_sel, pos_y[7:3], pos_x[7:3]};
        if (i_cfg.lcd_control[4]) begin
            data_base = {1'b0, r_tile_index, 4'b0000};
        end else begin
            data_base = 13'h0800 + {1'b0, r_tile_index ^ 8'h80, 4'b0000};
        end
        low_addr = data_base | {9'd0, r_tile_row_y[2:0], 1'b0};
        case (i_q_cmd.op)
            K_FETCH_TILE: rd_addr = map_addr;
            K_DATA_LOW:   rd_addr = low_addr;
            default:      rd_addr = r_tile_data_address + 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_q_cmd.op == K_VRAM_WRITE) begin
            r_vram[i_q_cmd.vram_address] <= i_q_cmd.vram_data;
        end
        r_rd_data <= r_vram[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state             <= S_IDLE;
            r_rd_kind           <= K_VRAM_WRITE;
            r_refuse            <= 1'b0;
            r_bit               <= '0;
            r_pixel_column      <= '0;
            r_window_mode       <= 1'b0;
            r_scan_line         <= '0;
            r_tile_row_y        <= '0;
            r_tile_index        <= '0;
            r_tile_data_address <= '0;
            r_plane_low         <= '0;
            r_plane_high        <= '0;
            r_discard_count     <= '0;
            r_out_valid         <= 1'b0;
        end else begin
            if (r_state == S_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_rd_kind <= i_q_cmd.op;
                        case (i_q_cmd.op)
                            K_LINE_START: begin
                                r_pixel_column <= i_q_cmd.start_column;
                                r_window_mode  <= i_q_cmd.window_select;
                                r_scan_line    <= i_q_cmd.line_number;
                            end
                            K_FETCH_TILE: begin
                                r_tile_row_y <= pos_y;
                                if (r_pixel_column == '0) begin
                                    r_discard_count <= i_cfg.scroll_x[2:0];
                                end
                                r_state <= S_READ;
                            end
                            K_DATA_LOW: begin
                                r_tile_data_address <= low_addr;
                                r_state             <= S_READ;
                            end
                            K_DATA_HIGH: begin
                                r_state <= S_READ;
                            end
                            K_PUSH: begin
                                r_refuse <= i_q_cmd.fill_over;
                                if (!i_q_cmd.fill_over) begin
                                    r_bit           <= r_discard_count;
                                    r_discard_count <= '0;
                                    r_pixel_column  <= r_pixel_column + 8'd8;
                                end
                                r_state <= S_PUSH;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    case (r_rd_kind)
                        K_FETCH_TILE: r_tile_index <= r_rd_data;
                        K_DATA_LOW:   r_plane_low  <= r_rd_data;
                        default:      r_plane_high <= r_rd_data;
                    endcase
                    r_state <= S_IDLE;
                end
                S_PUSH: begin
                    if (out_free) begin
                        if (r_refuse) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_bit <= r_bit + 1'b1;
                            if (r_bit == 3'd7) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // hold the word until taken
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH && out_free) begin
            if (r_refuse) begin
                r_pixel_color <= 2'b00;
                r_refused     <= 1'b1;
                r_last_pixel  <= 1'b1;
            end else begin
                r_pixel_color <= {r_plane_high[~r_bit], r_plane_low[~r_bit]};
                r_refused     <= 1'b0;
                r_last_pixel  <= r_bit == 3'd7;
            end
        end
    end

endmodule
